>>> design/sitda_pkg.sv
// Shared types, character codes and the power-of-ten table for the
// signed integer to decimal ASCII converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned PROD_W  = 34;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic setup;
        logic emit;
    } t_sitda_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic final_char;
    } t_sitda_sts;

    // Ten to the power idx, widened so that nine times it still fits.
    function automatic logic [PROD_W-1:0] sitda_pow10(input logic [IDX_W-1:0] idx);
        logic [PROD_W-1:0] p;
        case (idx)
            4'd0: p = 34'd1;
            4'd1: p = 34'd10;
            4'd2: p = 34'd100;
            4'd3: p = 34'd1000;
            4'd4: p = 34'd10000;
            4'd5: p = 34'd100000;
            4'd6: p = 34'd1000000;
            4'd7: p = 34'd10000000;
            4'd8: p = 34'd100000000;
            4'd9: p = 34'd1000000000;
            default: p = 34'd1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

>>> design/sitda_datapath.sv
// Datapath of the converter: magnitude register, digit position counter and
// the output character register. Depends on sitda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sitda_datapath
    import sitda_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic [VALUE_W-1:0]  i_value,
    input  wire t_sitda_cmd          i_cmd,
    output t_sitda_sts               o_sts,
    output logic [CHAR_W-1:0]        o_char,
    output logic                     o_last
);

    logic [VALUE_W-1:0] r_mag;
    logic [IDX_W-1:0]   r_idx;
    logic               r_sign_pend;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;

    logic [PROD_W-1:0]  w_pow;
    logic [PROD_W-1:0]  w_prod [10];
    logic [IDX_W-1:0]   w_digit;
    logic [VALUE_W-1:0] w_rem;
    logic [IDX_W-1:0]   w_ndig;

    // One decimal digit per cycle, held while the output stalls: the digit is the
    // largest multiple of the current power of ten that still fits under the magnitude.
    always_comb begin
        w_pow = sitda_pow10(r_idx);
        for (int k = 0; k < 10; k++) begin
            w_prod[k] = PROD_W'(k) * w_pow;
        end
        w_digit = '0;
        for (int k = 1; k < 10; k++) begin
            if ({2'b00, r_mag} >= w_prod[k]) begin
                w_digit = IDX_W'(k);
            end
        end
        w_rem = r_mag - w_prod[w_digit][VALUE_W-1:0];
        // Position of the leading digit, so that no leading zero is sent.
        w_ndig = '0;
        for (int j = 1; j < 10; j++) begin
            if ({2'b00, r_mag} >= sitda_pow10(IDX_W'(j))) begin
                w_ndig = IDX_W'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sign_pend <= i_value[VALUE_W-1];
            r_mag       <= i_value[VALUE_W-1] ? (VALUE_W'(0) - i_value) : i_value;
        end
        if (i_cmd.setup) begin
            r_idx <= w_ndig;
        end
        if (i_cmd.emit) begin
            if (r_sign_pend) begin
                r_char      <= CHAR_MINUS;
                r_last      <= 1'b0;
                r_sign_pend <= 1'b0;
            end else begin
                r_char <= CHAR_ZERO + {4'b0000, w_digit};
                r_last <= (r_idx == '0);
                r_mag  <= w_rem;
                r_idx  <= r_idx - 1'b1;
            end
        end
    end

    assign o_sts.final_char   = !r_sign_pend && (r_idx == '0);
    assign o_char             = r_char;
    assign o_last             = r_last;

endmodule

`default_nettype wire

>>> design/sitda_ctrl.sv
// Controller of the converter: sequences load, digit count and character
// emission, and owns the output valid flag. Depends on sitda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sitda_ctrl
    import sitda_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_sitda_sts i_sts,
    output t_sitda_cmd      o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_valid;
    logic       n_valid;
    logic       w_free;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        w_free  = !r_valid || i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.final_char) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (o_cmd.emit) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_valid;

endmodule

`default_nettype wire

>>> design/signed_int_to_decimal_ascii_top.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Instantiates sitda_ctrl and sitda_datapath; depends on sitda_pkg.
//
// Channel   Direction  Ports                       Payload
// s (in)    slave      i_s_tvalid / o_s_tready     i_s_tdata[31:0] = value
// m (out)   master     o_m_tvalid / i_m_tready     o_m_tdata[7:0] = character,
//                                                  o_m_tlast = last
//
// An item of N characters (1 to 11) is first accepted, then a bank of constant
// compares finds the leading digit position, and then the digit unit sends one
// character per cycle while the output is not stalled; it compares the magnitude
// against the nine multiples of the current power of ten. Reset (synchronous,
// active low) clears only the controller state and the output valid flag. A
// stalled output holds the character register and pauses emission; a new item
// is accepted as soon as the final character of the previous one has been
// loaded.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii_top
    import sitda_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [VALUE_W-1:0] i_s_tdata,   // [31:0] value (signed)
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [CHAR_W-1:0]       o_m_tdata,   // [7:0] character
    output logic                    o_m_tlast
);

    // Commands and status between the sequencer and the datapath.
    t_sitda_cmd w_cmd;
    t_sitda_sts w_sts;

    sitda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sitda_datapath u_datapath (
        .i_clk   (i_clk),
        .i_value (i_s_tdata),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_char  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

`ifndef SYNTHESIS
    // Only one number is in conversion at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while a conversion was running");

    // While a character that is not the final one waits, the number is unfinished.
    a_busy_mid_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> !o_s_tready)
        else $error("input ready in the middle of a number");

    // Every character sent is a minus sign or a decimal digit.
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata == CHAR_MINUS) ||
                        ((o_m_tdata >= CHAR_ZERO) && (o_m_tdata <= CHAR_NINE))))
        else $error("illegal output character");
`endif

endmodule

`default_nettype wire

>>> tb/sv/decimal_ascii_checker.sv
// Checker for the signed integer to decimal ASCII converter: watches both
// stream channels, predicts the character sequence and compares it.
// Depends on sitda_pkg for widths and character codes.
`timescale 1ns / 1ps

module decimal_ascii_checker
    import sitda_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    input  wire logic               i_s_tready,
    input  wire logic [VALUE_W-1:0] i_s_tdata,   // [31:0] value (signed)
    input  wire logic               i_m_tvalid,
    input  wire logic               i_m_tready,
    input  wire logic [CHAR_W-1:0]  i_m_tdata,   // [7:0] character
    input  wire logic               i_m_tlast,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_item;

    t_char_item expected_chars[$];
    int         fail_count = 0;

    // Appends the decimal spelling of one value, sign first, then digits
    // from the most significant one down.
    function automatic void spell_decimal(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digits [10];
        int                 nd;
        t_char_item         ch;
        mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
        nd  = 0;
        do begin
            digits[nd] = 4'(mag % 10);
            nd++;
            mag = mag / 10;
        end while (mag != 0 && nd < 10);
        if (raw[VALUE_W-1]) begin
            ch.code = CHAR_MINUS;
            ch.last = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int k = nd; k > 0; k--) begin
            ch.code = CHAR_ZERO + CHAR_W'(digits[k-1]);
            ch.last = (k == 1);
            expected_chars.push_back(ch);
        end
    endfunction

    always @(posedge i_clk) begin
        t_char_item want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                spell_decimal(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_chars.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("[%0t] unexpected character 0x%02h last=%0b",
                                 $realtime, i_m_tdata, i_m_tlast);
                    end
                    fail_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_m_tdata !== want.code || i_m_tlast !== want.last) begin
                        if (fail_count < 10) begin
                            $display("[%0t] mismatch: exp 0x%02h/%0b got 0x%02h/%0b",
                                     $realtime, want.code, want.last,
                                     i_m_tdata, i_m_tlast);
                        end
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_chars.size();
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the testbench for signed_int_to_decimal_ascii_top: clock, reset,
// stimulus and verdict. Depends on sitda_pkg and decimal_ascii_checker.
`timescale 1ns / 1ps

module testbench
    import sitda_pkg::*;
();

    // Even with heavy output stalls and sender gaps the whole run stays well
    // under this bound.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 450;
    // The receiver goes quiet for a long stretch once, mid-run, so that the
    // block fills up and pushes back on the sender.
    localparam int HOLD_START   = 2500;
    localparam int HOLD_LEN     = 400;
    localparam int TAIL_CYCLES  = 40;

    // Directed values: zero, small and decade boundaries, both extremes and
    // their neighbors, and alternating bit patterns so that every input bit
    // takes both values.
    localparam logic [VALUE_W-1:0] DIRECTED [20] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'd9,
        32'd10,        -32'sd10,      32'd99,        32'd100,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
        32'd999999999, -32'sd999999999, -32'sd1000000000, 32'd1234567890,
        32'h5555_5555, 32'hAAAA_AAAA, -32'sd7,       32'h7FFF_FFFE
    };

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [VALUE_W-1:0] s_tdata  = '0;
    logic               m_tready = 1'b0;
    logic               s_tready;
    logic               m_tvalid;
    logic [CHAR_W-1:0]  m_tdata;
    logic               m_tlast;
    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;

    signed_int_to_decimal_ascii_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    decimal_ascii_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Watchdog. A hung handshake or a lost character ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Random value with a spread of character counts: roughly a third fully
    // random 32-bit patterns, some values near zero, the extremes and one billion,
    // and the rest drawn with a random number of digits and a random sign.
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned        sel;
        int unsigned        ndig;
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        p;
        logic [VALUE_W-1:0] v;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            v = $urandom();
        end else if (sel == 3) begin
            case ($urandom_range(0, 3))
                0:       v = 32'(signed'($urandom_range(0, 4)) - 2);
                1:       v = 32'h7FFF_FFFF - $urandom_range(0, 3);
                2:       v = 32'h8000_0000 + $urandom_range(0, 3);
                default: v = 32'd1000000000 - $urandom_range(0, 2);
            endcase
        end else begin
            ndig = $urandom_range(1, 10);
            p = 1;
            repeat (ndig - 1) p = p * 10;
            lo = (ndig == 1) ? 0 : p;
            hi = (ndig == 10) ? 32'h7FFF_FFFF : p * 10 - 1;
            v = $urandom_range(hi, lo);
            if ($urandom_range(0, 1) == 1) begin
                v = -v;
            end
        end
        return v;
    endfunction

    // Offers one item and returns at the edge where it is taken. Valid stays
    // high on return, so back-to-back calls form a burst without a bubble.
    task automatic offer_value(input logic [VALUE_W-1:0] v);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge clk); while (!s_tready);
    endtask

    // Output side: stretches of always-ready, random stalls, and mostly
    // stalled, plus the one long hold-off counted in this process's own
    // cycles.
    initial begin : receiver
        int unsigned mode;
        int unsigned span;
        int          rx_cycles;
        bit          hold_done;
        rx_cycles = 0;
        hold_done = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 40);
            repeat (span) begin
                @(posedge clk);
                rx_cycles++;
                if (!hold_done && rx_cycles >= HOLD_START) begin
                    m_tready <= 1'b0;
                    repeat (HOLD_LEN) @(posedge clk);
                    rx_cycles += HOLD_LEN;
                    hold_done = 1'b1;
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Input side and verdict.
    initial begin : stimulus
        logic [VALUE_W-1:0] values[$];
        int unsigned        burst;
        int unsigned        gap;
        int                 idx;
        foreach (DIRECTED[i]) values.push_back(DIRECTED[i]);
        repeat (RANDOM_ITEMS) values.push_back(pick_value());

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed items go out as one unbroken burst; after that the
        // sender alternates random bursts and random gaps, with a gap of
        // zero now and then so that bursts also run into each other.
        idx = 0;
        while (idx < values.size()) begin
            burst = (idx == 0) ? $size(DIRECTED) : $urandom_range(1, 12);
            repeat (burst) begin
                if (idx < values.size()) begin
                    offer_value(values[idx]);
                    idx++;
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= $urandom();
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;

        // Drain: every predicted character must come out, then a quiet tail
        // catches anything extra the block might still emit.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/sitda_pkg.sv
design/sitda_datapath.sv
design/sitda_ctrl.sv
design/signed_int_to_decimal_ascii_top.sv
tb/sv/decimal_ascii_checker.sv
tb/sv/testbench.sv
